// ===== src/bol_pkg.sv =====
// Shared constants, types and cell control bundle for the bounded ordered list.
package bol_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 2;
  localparam int FPOS_W   = 5;
  localparam int LEN_W    = 6;

  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT  = 3'd0,
    CMD_ADD_BACK   = 3'd1,
    CMD_TAKE_FRONT = 3'd2,
    CMD_TAKE_BACK  = 3'd3,
    CMD_INSERT     = 3'd4,
    CMD_SEARCH     = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_EMPTY  = 2'd1,
    STAT_BEYOND = 2'd2,
    STAT_FULL   = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL
  } cell_op_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   ins_pos;
    logic [VALUE_W-1:0] data;        // new value or search key
    logic [CNT_W-1:0]   count;
    logic               match_load;
    logic               match_shift;
  } cell_ctrl_t;

endpackage

// ===== src/bol_cell.sv =====
// One list slot: holds a value and a match flag, shifts with its neighbours.
module bol_cell
  import bol_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic [IDX_W-1:0]   my_idx,
  input  logic [VALUE_W-1:0] left_value,
  input  logic [VALUE_W-1:0] right_value,
  input  logic               right_match,
  output logic [VALUE_W-1:0] value,
  output logic               match
);

  logic [VALUE_W-1:0] value_r, value_nxt;
  logic               match_r, match_nxt;
  logic               live;

  assign live = {{(CNT_W-IDX_W){1'b0}}, my_idx} < ctrl.count;

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      OP_INS: begin
        if (my_idx == ctrl.ins_pos) begin
          value_nxt = ctrl.data;
        end else if (my_idx > ctrl.ins_pos) begin
          value_nxt = left_value;
        end
      end
      OP_DEL: value_nxt = right_value;
      default: value_nxt = value_r;
    endcase
  end

  always_comb begin
    match_nxt = match_r;
    if (ctrl.match_load) begin
      match_nxt = (value_r == ctrl.data) && live;
    end else if (ctrl.match_shift) begin
      match_nxt = right_match;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign value = value_r;
  assign match = match_r;

endmodule

// ===== src/bounded_ordered_list_top.sv =====
// Top level of the bounded ordered list: command decode, scan control and cell row.
//
//  channel | dir | tdata / tuser                               | accepted when
//  in_     | in  | tdata: value[31:0] position[37:32]; tuser: cmd | tvalid & tready
//  out_    | out | tdata: status[1:0] found[2] fpos[7:3] len[13:8]  | tvalid & tready
//
// Push, pop, insert and unused codes: the whole row shifts at once and the result word is registered.
// Search: the per-cell matches are latched first, then the match flags walk towards cell 0
// until cell 0 holds a match or the last entry is reached; an empty list answers at once.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// slot contents are not cleared.
// One result word register sits at the output; while it holds an unaccepted word
// no new input word is taken. A search empties it on acceptance, so the scan
// never waits at its final step.
module bounded_ordered_list_top
  import bol_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[37:32], zero pad
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], found[2], found_position[7:3],
                                  // length[13:8], zero pad
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_r, scan_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               found_r, found_nxt;
  logic [FPOS_W-1:0]  fpos_r, fpos_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;

  cell_ctrl_t         ctrl;
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_match;

  logic [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]   in_position;
  cmd_t               in_cmd;
  logic               accept, out_free, full;
  logic [CMP_W-1:0]   pos_ext, cnt_ext, scan_ext, cnt_nxt_ext;

  assign in_value    = in_tdata[31:0];
  assign in_position = in_tdata[37:32];
  assign in_cmd      = cmd_t'(in_tuser);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_FULL);

  assign pos_ext     = {{(CMP_W-POS_W){1'b0}}, in_position};
  assign cnt_ext     = {{(CMP_W-CNT_W){1'b0}}, count_r};
  assign scan_ext    = {{(CMP_W-CNT_W){1'b0}}, scan_r};
  assign cnt_nxt_ext = {{(CMP_W-CNT_W){1'b0}}, count_nxt};

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    scan_nxt        = scan_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    status_nxt      = status_r;
    found_nxt       = found_r;
    fpos_nxt        = fpos_r;
    len_nxt         = len_r;
    ctrl.op          = OP_HOLD;
    ctrl.ins_pos     = '0;
    ctrl.data        = in_value;
    ctrl.count       = count_r;
    ctrl.match_load  = 1'b0;
    ctrl.match_shift = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt    = STAT_DONE;
          found_nxt     = 1'b0;
          fpos_nxt      = '0;
          out_valid_nxt = 1'b1;
          case (in_cmd)
            CMD_ADD_FRONT, CMD_ADD_BACK: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ctrl.op      = OP_INS;
                ctrl.ins_pos = (in_cmd == CMD_ADD_FRONT) ? '0 : count_r[IDX_W-1:0];
                count_nxt    = count_r + CNT_ONE;
              end
            end
            CMD_TAKE_FRONT, CMD_TAKE_BACK: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                // popping the back only drops the count
                if (in_cmd == CMD_TAKE_FRONT) ctrl.op = OP_DEL;
                count_nxt = count_r - CNT_ONE;
              end
            end
            CMD_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_nxt = STAT_BEYOND;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ctrl.op      = OP_INS;
                ctrl.ins_pos = pos_ext[IDX_W-1:0];
                count_nxt    = count_r + CNT_ONE;
              end
            end
            CMD_SEARCH: begin
              if (count_r != '0) begin
                ctrl.match_load = 1'b1;
                out_valid_nxt   = 1'b0;
                scan_nxt        = '0;
                state_nxt       = S_SCAN;
              end
            end
            default: status_nxt = STAT_DONE;
          endcase
          len_nxt = cnt_nxt_ext[LEN_W-1:0];
        end
      end

      S_SCAN: begin
        if (cell_match[0] || (scan_r + CNT_ONE == count_r)) begin
          // final step: needs the output slot
          if (out_free) begin
            out_valid_nxt = 1'b1;
            status_nxt    = STAT_DONE;
            found_nxt     = cell_match[0];
            fpos_nxt      = cell_match[0] ? scan_ext[FPOS_W-1:0] : '0;
            len_nxt       = cnt_ext[LEN_W-1:0];
            state_nxt     = S_IDLE;
          end
        end else begin
          ctrl.match_shift = 1'b1;
          scan_nxt         = scan_r + CNT_ONE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
    len_r    <= len_nxt;
  end

  // row of cells, position 0 at the front
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_v, right_v;
    logic               right_m;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
      assign right_m = 1'b0;
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
      assign right_m = cell_match[i+1];
    end

    bol_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .my_idx      (IDX_W'(i)),
      .left_value  (left_v),
      .right_value (right_v),
      .right_match (right_m),
      .value       (cell_value[i]),
      .match       (cell_match[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, len_r, fpos_r, found_r, status_r};

endmodule

// ===== bench/tb_bounded_ordered_list_top.sv =====
// Self-checking bench for the bounded ordered list: directed and biased random commands.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_top;
  import bol_pkg::*;

  // codes 6 and 7 have no enum member; the block must treat them as no-ops
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STALL_LIMIT  = 4000;          // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = CAPACITY + 8;  // outlasts the longest search

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } list_cmd_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [FPOS_W-1:0] found_pos;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  typedef enum int {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_MIXED
  } bias_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // value[31:0], position[37:32], zero pad
  logic [2:0]  in_tuser = '0;   // cmd[2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // status[1:0], found[2], found_position[7:3], length[13:8]

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int           total_items;
  int           items_issued = 0;
  int           results_checked = 0;
  int           error_count = 0;
  int           stall_cycles = 0;
  logic         in_taken = 1'b0;   // word accepted at the last rising edge

  // shadow copy of the list, front at index 0
  logic [VALUE_W-1:0] shadow_list [CAPACITY];
  int                 shadow_len = 0;

  bounded_ordered_list_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow list model
  // ---------------------------------------------------------------------------

  function automatic void place_entry(input int pos, input logic [VALUE_W-1:0] v);
    for (int i = shadow_len; i > pos; i--) begin
      shadow_list[i] = shadow_list[i-1];
    end
    shadow_list[pos] = v;
    shadow_len++;
  endfunction

  // Applies one command to the shadow list and returns the word the block should emit
  function automatic list_result_t apply_command(input list_cmd_t c);
    list_result_t r;
    int           drop_pos;
    r.status    = STAT_DONE;
    r.found     = 1'b0;
    r.found_pos = '0;
    case (c.cmd)
      CMD_ADD_FRONT, CMD_ADD_BACK: begin
        if (shadow_len >= CAPACITY) r.status = STAT_FULL;
        else place_entry((c.cmd == CMD_ADD_FRONT) ? 0 : shadow_len, c.value);
      end
      CMD_TAKE_FRONT, CMD_TAKE_BACK: begin
        if (shadow_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          drop_pos = (c.cmd == CMD_TAKE_FRONT) ? 0 : shadow_len - 1;
          for (int i = drop_pos; i + 1 < shadow_len; i++) begin
            shadow_list[i] = shadow_list[i+1];
          end
          shadow_len--;
        end
      end
      CMD_INSERT: begin
        // range is checked before fullness
        if (int'(c.position) > shadow_len) r.status = STAT_BEYOND;
        else if (shadow_len >= CAPACITY) r.status = STAT_FULL;
        else place_entry(int'(c.position), c.value);
      end
      CMD_SEARCH: begin
        // first match wins; done status whether found or not
        for (int i = 0; i < shadow_len && !r.found; i++) begin
          if (shadow_list[i] == c.value) begin
            r.found     = 1'b1;
            r.found_pos = FPOS_W'(i);
          end
        end
      end
      default: ;  // spare codes leave the list alone
    endcase
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling plan: sender 28 / receiver 47, then swapped, then no idling
  // ---------------------------------------------------------------------------

  function automatic int idle_pct(input bit receiver);
    int third;
    third = (total_items + 2) / 3;
    if (items_issued < third) return receiver ? 47 : 28;
    if (items_issued < 2 * third) return receiver ? 28 : 47;
    return 0;
  endfunction

  function automatic void queue_cmd(input logic [CMD_W-1:0] cmd,
                                    input logic [VALUE_W-1:0] value,
                                    input logic [POS_W-1:0] position);
    list_cmd_t c;
    c.cmd      = cmd;
    c.value    = value;
    c.position = position;
    pending_cmds = {pending_cmds, c};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: new word or idle at the falling edge, once the old one has gone
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    list_cmd_t c;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        c = pending_cmds[0];
        pending_cmds.delete(0);
        items_issued++;
        in_tdata  <= {2'b00, c.position, c.value};
        in_tuser  <= c.cmd;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  // ---------------------------------------------------------------------------
  // Monitor: accepted commands feed the model, accepted results are checked
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    list_cmd_t    c;
    list_result_t want;
    logic         took;
    took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.value    = in_tdata[31:0];
        c.position = in_tdata[37:32];
        c.cmd      = in_tuser;
        want = apply_command(c);
        expected_results = {expected_results, want};
        took = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          error_count++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (out_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[1:0]);
            error_count++;
          end
          if (out_tdata[2] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_tdata[2]);
            error_count++;
          end
          if (out_tdata[7:3] !== want.found_pos) begin
            $error("found_position: expected %0d, got %0d", want.found_pos, out_tdata[7:3]);
            error_count++;
          end
          if (out_tdata[13:8] !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_tdata[13:8]);
            error_count++;
          end
        end
      end
    end
    in_taken <= took;
  end

  // watchdog on traffic stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [VALUE_W-1:0] pool [8];
    logic [VALUE_W-1:0] val;
    logic [CMD_W-1:0]   op;
    logic [POS_W-1:0]   pos;
    bias_t              bias;
    int                 run_left;
    int                 r;
    int                 add_pct;
    int                 pop_pct;

    foreach (pool[i]) pool[i] = $urandom();

    // directed: empty-list cases first
    queue_cmd(CMD_TAKE_FRONT, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_TAKE_BACK, 32'hFFFF_FFFF, 6'd63);
    queue_cmd(CMD_SEARCH, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_INSERT, 32'h1234_5678, 6'd1);       // beyond length on empty list
    queue_cmd(CMD_INSERT, 32'h0000_0001, 6'd0);       // position 0 acts as push front
    queue_cmd(CMD_ADD_BACK, 32'h8000_0000, 6'd0);
    queue_cmd(CMD_ADD_FRONT, 32'h7FFF_FFFF, 6'd0);
    queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd3);       // position equal to length appends
    queue_cmd(CMD_INSERT, 32'h5555_5555, 6'd63);      // far beyond length
    queue_cmd(CMD_INSERT, 32'hAAAA_AAAA, 6'd2);       // middle
    queue_cmd(CMD_SEARCH, 32'hFFFF_FFFF, 6'd0);
    queue_cmd(CMD_SEARCH, 32'h7FFF_FFFF, 6'd0);
    queue_cmd(CMD_SEARCH, 32'h1234_5678, 6'd0);       // absent key
    queue_cmd(CMD_ADD_BACK, 32'h0000_0001, 6'd0);     // duplicate key
    queue_cmd(CMD_SEARCH, 32'h0000_0001, 6'd0);       // first of two matches
    queue_cmd(CMD_SPARE_6, 32'hAAAA_AAAA, 6'd42);
    queue_cmd(CMD_SPARE_7, 32'h5555_5555, 6'd21);
    queue_cmd(CMD_TAKE_FRONT, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_TAKE_BACK, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_TAKE_BACK, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_TAKE_FRONT, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_TAKE_BACK, 32'h0000_0000, 6'd0);    // leaves one element, which the next pop takes from the back
    queue_cmd(CMD_TAKE_BACK, 32'h0000_0000, 6'd0);
    queue_cmd(CMD_SEARCH, 32'h8000_0000, 6'd0);

    // random: runs that fill, drain or mix so the list swings between empty and full
    bias     = BIAS_FILL;
    run_left = $urandom_range(40, 90);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        bias     = bias_t'($urandom_range(0, 2));
        run_left = $urandom_range(30, 90);
      end
      run_left--;
      case (bias)
        BIAS_FILL:  begin add_pct = 72; pop_pct = 8;  end
        BIAS_DRAIN: begin add_pct = 15; pop_pct = 60; end
        default:    begin add_pct = 35; pop_pct = 30; end
      endcase

      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        case ($urandom_range(0, 2))
          0:       op = CMD_ADD_FRONT;
          1:       op = CMD_ADD_BACK;
          default: op = CMD_INSERT;
        endcase
      end else if (r < add_pct + pop_pct) begin
        op = $urandom_range(0, 1) ? CMD_TAKE_FRONT : CMD_TAKE_BACK;
      end else if (r < 97) begin
        op = CMD_SEARCH;
      end else begin
        op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
      end

      // pooled values give duplicates and search hits
      r = $urandom_range(0, 9);
      if (r < 5) begin
        val = pool[$urandom_range(0, 7)];
      end else if (r < 6) begin
        case ($urandom_range(0, 4))
          0:       val = 32'h0000_0000;
          1:       val = 32'h0000_0001;
          2:       val = 32'h7FFF_FFFF;
          3:       val = 32'h8000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end else begin
        val = $urandom();
      end

      // mostly within 0..CAPACITY+1, sometimes anywhere in the field
      pos = ($urandom_range(0, 4) != 0) ? POS_W'($urandom_range(0, CAPACITY + 1))
                                        : POS_W'($urandom_range(0, 63));
      queue_cmd(op, val, pos);
    end
    total_items = pending_cmds.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every word answered, then watch a while for stray results
    @(negedge clk);
    while (results_checked < total_items) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && results_checked == total_items &&
        expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
